/* design/sjt_pkg.sv */
package sjt_pkg;

	// Field widths fixed by the interface.
	localparam int RANK_W       = 45;
	localparam int SIZE_W       = 5;
	localparam int NIB_W        = 4;
	localparam int PERM_W       = 64;
	localparam int MASK_W       = 16;
	localparam int MASK_IDX_W   = 4;
	localparam int MAX_ELEM_DEF = 16;

	// The divider retires two quotient bits per cycle over a padded rank.
	localparam int DIV_W     = RANK_W + 1;
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int CNT_W     = 5;

	// Reset value of the size register and the mobility mask at rank zero.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic [MASK_W-1:0] ACT_RANK0  = 16'hFFFE;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_WANT,
		ST_SCAN,
		ST_FINISH
	} sjt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic start;
		logic div_step;
		logic want;
		logic scan_step;
		logic load_out;
	} sjt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad_rank;
		logic zero_rank;
		logic div_last;
		logic scan_hit;
		logic last_digit;
	} sjt_stat_t;

	// Factorial of k for k up to sixteen.
	function automatic logic [RANK_W-1:0] fact_of(input logic [SIZE_W-1:0] k);
		logic [RANK_W-1:0] f;
		case (k)
			5'd0:    f = 45'd1;
			5'd1:    f = 45'd1;
			5'd2:    f = 45'd2;
			5'd3:    f = 45'd6;
			5'd4:    f = 45'd24;
			5'd5:    f = 45'd120;
			5'd6:    f = 45'd720;
			5'd7:    f = 45'd5040;
			5'd8:    f = 45'd40320;
			5'd9:    f = 45'd362880;
			5'd10:   f = 45'd3628800;
			5'd11:   f = 45'd39916800;
			5'd12:   f = 45'd479001600;
			5'd13:   f = 45'd6227020800;
			5'd14:   f = 45'd87178291200;
			5'd15:   f = 45'd1307674368000;
			5'd16:   f = 45'd20922789888000;
			default: f = 45'd20922789888000;
		endcase
		return f;
	endfunction

endpackage

/* design/sjt_control.sv */
module sjt_control
	import sjt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  sjt_stat_t stat,
	output sjt_cmd_t  cmd
);

	sjt_state_t state_q, state_next;
	logic       out_valid_q;

	// State register and output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_START;
			end
			ST_START: begin
				if (stat.bad_rank || stat.zero_rank) state_next = ST_FINISH;
				else state_next = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) state_next = ST_WANT;
			end
			ST_WANT: begin
				state_next = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.scan_hit) begin
					state_next = stat.last_digit ? ST_FINISH : ST_DIV;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_START:  cmd.start     = 1'b1;
			ST_DIV:    cmd.div_step  = 1'b1;
			ST_WANT:   cmd.want      = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_FINISH: cmd.load_out  = !out_valid_q || out_ready;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// A loaded result is offered in the following cycle.
	a_load_offers: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result load did not raise out_valid");

	// A pending result that is not taken holds the finished item back.
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_valid_q && !out_ready |=> state_q == ST_FINISH)
		else $error("finished item left while the output register was full");

	// An accepted beat always starts the range check next.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_START)
		else $error("accepted rank did not start processing");

endmodule

/* design/sjt_datapath.sv */
module sjt_datapath
	import sjt_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic [RANK_W-1:0] rank,
	input  sjt_cmd_t          cmd,
	output sjt_stat_t         stat,
	output logic [PERM_W-1:0] permutation,
	output logic [PERM_W-1:0] positions,
	output logic [MASK_W-1:0] direction_bits,
	output logic [MASK_W-1:0] active_bits,
	output logic              rank_error
);

	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_ELEMENTS);

	logic [SIZE_W-1:0]   perm_size_q;
	logic [SIZE_W-1:0]   n_eff;
	logic [SIZE_W-1:0]   n_q;
	logic [SIZE_W-1:0]   m_q;
	logic [SIZE_W-1:0]   m_dec;
	logic [DIV_W-1:0]    r_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MAX_ELEMENTS-1:0] free_q;
	logic [NIB_W-1:0]    slot_q [MAX_ELEMENTS];
	logic [NIB_W-1:0]    pos_q  [MAX_ELEMENTS];
	logic [IDX_W-1:0]    scan_q;
	logic [NIB_W-1:0]    seen_q;
	logic [NIB_W-1:0]    want_q;
	logic [MASK_W-1:0]   dir_q;
	logic [MASK_W-1:0]   act_q;
	logic                err_q;
	logic                zero_q;

	logic [SIZE_W:0]     p1, p2;
	logic                b1, b2;
	logic [SIZE_W-1:0]   r1, r2;
	logic [SIZE_W-1:0]   want_full;
	logic [SIZE_W-1:0]   lvl_full;
	logic                lvl_used;
	logic                hit;

	logic [PERM_W-1:0]   perm_next;
	logic [PERM_W-1:0]   pos_next;
	logic [MASK_W-1:0]   dir_next;
	logic [MASK_W-1:0]   act_next;

	// Size register; an out-of-range size is clamped where it is used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			perm_size_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (perm_size_q == '0) n_eff = SIZE_W'(1);
		else if (perm_size_q > MAX_N) n_eff = MAX_N;
		else n_eff = perm_size_q;
	end

	// Two restoring division steps per cycle by the current radix.
	always_comb begin
		p1 = {rem_q, r_q[DIV_W-1]};
		b1 = p1 >= {1'b0, m_q};
		r1 = b1 ? SIZE_W'(p1 - {1'b0, m_q}) : p1[SIZE_W-1:0];
		p2 = {r1, r_q[DIV_W-2]};
		b2 = p2 >= {1'b0, m_q};
		r2 = b2 ? SIZE_W'(p2 - {1'b0, m_q}) : p2[SIZE_W-1:0];
	end

	// Digit selection: an even quotient counts free slots from the high end.
	always_comb begin
		m_dec     = m_q - SIZE_W'(1);
		want_full = r_q[0] ? rem_q : SIZE_W'(m_dec - rem_q);
		lvl_full  = n_q - m_q;
		lvl_used  = (m_q >= SIZE_W'(2)) && (m_q < n_q);
		hit       = free_q[scan_q] && (seen_q == want_q);
	end

	// Status toward the controller.
	always_comb begin
		stat.bad_rank   = r_q[RANK_W-1:0] >= fact_of(n_q);
		stat.zero_rank  = r_q == '0;
		stat.div_last   = cnt_q == CNT_W'(DIV_STEPS - 1);
		stat.scan_hit   = hit;
		stat.last_digit = m_q == SIZE_W'(1);
	end

	// Working registers of the digit loop.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_q <= {1'b0, rank};
			n_q <= n_eff;
		end
		if (cmd.start) begin
			err_q  <= stat.bad_rank;
			zero_q <= stat.zero_rank;
			m_q    <= n_q;
			rem_q  <= '0;
			cnt_q  <= '0;
			dir_q  <= '0;
			act_q  <= '0;
			for (int s = 0; s < MAX_ELEMENTS; s++) begin
				free_q[s] <= SIZE_W'(s) < n_q;
				slot_q[s] <= '0;
				pos_q[s]  <= '0;
			end
		end
		if (cmd.div_step) begin
			r_q   <= {r_q[DIV_W-3:0], b1, b2};
			rem_q <= r2;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (cmd.want) begin
			want_q <= want_full[NIB_W-1:0];
			scan_q <= '0;
			seen_q <= '0;
			if (lvl_used) begin
				dir_q[lvl_full[MASK_IDX_W-1:0]] <= r_q[0];
				act_q[lvl_full[MASK_IDX_W-1:0]] <= rem_q != m_dec;
			end
		end
		if (cmd.scan_step) begin
			scan_q <= scan_q + IDX_W'(1);
			if (hit) begin
				// Place element m-1 in this slot and move to the next radix.
				slot_q[scan_q]             <= m_dec[NIB_W-1:0];
				pos_q[m_dec[IDX_W-1:0]]    <= NIB_W'(scan_q);
				free_q[scan_q]             <= 1'b0;
				m_q                        <= m_dec;
				rem_q                      <= '0;
				cnt_q                      <= '0;
			end else if (free_q[scan_q]) begin
				seen_q <= seen_q + NIB_W'(1);
			end
		end
	end

	// Result assembly for the three cases.
	always_comb begin
		perm_next = '0;
		pos_next  = '0;
		dir_next  = '0;
		act_next  = '0;
		if (zero_q) begin
			for (int i = 0; i < MAX_ELEMENTS; i++) begin
				if (SIZE_W'(i) < n_q) begin
					perm_next[NIB_W*i +: NIB_W] = NIB_W'(i);
					pos_next[NIB_W*i +: NIB_W]  = NIB_W'(i);
				end
			end
			act_next = ACT_RANK0;
		end else if (!err_q) begin
			for (int i = 0; i < MAX_ELEMENTS; i++) begin
				perm_next[NIB_W*i +: NIB_W] = slot_q[i];
				pos_next[NIB_W*i +: NIB_W]  = pos_q[i];
			end
			dir_next = dir_q;
			act_next = act_q;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			permutation    <= perm_next;
			positions      <= pos_next;
			direction_bits <= dir_next;
			active_bits    <= act_next;
			rank_error     <= err_q;
		end
	end

	// Each free slot stands for one radix still to be placed.
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> $countones(free_q) == int'(m_q))
		else $error("free slot count does not match the current radix");

endmodule

/* design/sjt_permutation_unrank.sv */
// Unranks a 45-bit rank into the permutation of 0..n-1 at that place in
// Johnson-Trotter order, with its inverse and the direction and mobility masks
// that let a generator resume there; n comes from the perm_size register,
// clamped to 1..MAX_ELEMENTS. One item is processed at a time. A rank of zero
// or a rank of n! or more skips the digit loop and goes straight to the
// result. Any other rank runs the digit loop for each of the n radices: the
// shared divider retires two quotient bits of the padded 46-bit rank per
// cycle, and then the free-slot scan visits one slot per cycle until it
// finds the slot for that digit. A finished result sits in an output
// register, so the next rank is taken while the previous result waits.
// perm_size must only be written while the block is idle.
module sjt_permutation_unrank
	import sjt_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [RANK_W-1:0] rank,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PERM_W-1:0] permutation,
	output logic [PERM_W-1:0] positions,
	output logic [MASK_W-1:0] direction_bits,
	output logic [MASK_W-1:0] active_bits,
	output logic              rank_error
);

	sjt_cmd_t  cmd;
	sjt_stat_t stat;

	// Sequencer for the digit loop and the output beat.
	sjt_control u_control (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Divider, slot scan, masks and result register.
	sjt_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.rank           (rank),
		.cmd            (cmd),
		.stat           (stat),
		.permutation    (permutation),
		.positions      (positions),
		.direction_bits (direction_bits),
		.active_bits    (active_bits),
		.rank_error     (rank_error)
	);

endmodule

/* tb/tb_top.sv */
module tb_top;
	import sjt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Longest run of cycles with no beat on either channel before the run is abandoned.
	localparam int WATCHDOG_LIMIT = 20000;
	// Worst unranking time for sixteen elements, with some margin.
	localparam int SETTLE_CYCLES  = 700;
	localparam int HOLDOFF_CYCLES = 3000;

	typedef struct {
		logic [PERM_W-1:0] permutation;
		logic [PERM_W-1:0] positions;
		logic [MASK_W-1:0] direction_bits;
		logic [MASK_W-1:0] active_bits;
		logic              rank_error;
	} unrank_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic [RANK_W-1:0] rank;
	logic              out_valid;
	logic              out_ready;
	logic [PERM_W-1:0] permutation;
	logic [PERM_W-1:0] positions;
	logic [MASK_W-1:0] direction_bits;
	logic [MASK_W-1:0] active_bits;
	logic              rank_error;

	unrank_result_t    pending_perms[$];
	logic [SIZE_W-1:0] size_seen = SIZE_RESET;
	int                error_count = 0;
	int                quiet_cycles = 0;
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                holdoff_left = 0;

	sjt_permutation_unrank u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rank          (rank),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.permutation   (permutation),
		.positions     (positions),
		.direction_bits(direction_bits),
		.active_bits   (active_bits),
		.rank_error    (rank_error)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned factorial(int k);
		longint unsigned f;
		f = 1;
		for (int j = 2; j <= k; j++) begin
			f = f * 64'(j);
		end
		return f;
	endfunction

	// The element count actually used for a register value: zero acts as one,
	// anything above sixteen acts as sixteen.
	function automatic int elem_count(logic [SIZE_W-1:0] size_reg);
		int n;
		n = int'(size_reg);
		if (n < 1) n = 1;
		if (n > 16) n = 16;
		return n;
	endfunction

	// Johnson-Trotter unranking: digits by repeated division, each placed in a free
	// slot counted from the end that the quotient parity selects.
	function automatic unrank_result_t predict_unrank(logic [RANK_W-1:0] r,
							  logic [SIZE_W-1:0] size_reg);
		unrank_result_t  res;
		int              n, m, want, seen, s, i, e;
		longint unsigned nf, rr, q, rem, span, delta, rem2;
		logic [15:0]     free_set;
		int              slot_elem[16];
		bit              placed, right;
		n = elem_count(size_reg);
		nf = factorial(n);
		res.permutation = '0;
		res.positions = '0;
		res.direction_bits = '0;
		res.active_bits = '0;
		res.rank_error = 1'b0;
		if (64'(r) >= nf) begin
			res.rank_error = 1'b1;
			return res;
		end
		if (r == '0) begin
			for (i = 0; i < n; i++) begin
				res.permutation[4*i +: 4] = 4'(i);
				res.positions[4*i +: 4] = 4'(i);
			end
			res.active_bits = ACT_RANK0;
			return res;
		end
		free_set = '0;
		for (i = 0; i < 16; i++) begin
			slot_elem[i] = 0;
			if (i < n) free_set[i] = 1'b1;
		end
		rr = 64'(r);
		for (m = n; m >= 1; m--) begin
			q = rr / 64'(m);
			rem = rr % 64'(m);
			want = q[0] ? int'(rem) : m - 1 - int'(rem);
			seen = 0;
			placed = 0;
			for (s = 0; s < n; s++) begin
				if (!placed && free_set[s]) begin
					if (seen == want) begin
						slot_elem[s] = m - 1;
						free_set[s] = 1'b0;
						placed = 1;
					end else begin
						seen++;
					end
				end
			end
			rr = q;
		end
		for (i = 0; i < n; i++) begin
			e = slot_elem[i];
			res.permutation[4*i +: 4] = 4'(e);
			res.positions[4*e +: 4] = 4'(i);
		end
		// Level masks come from the rank modulo twice the span of each level.
		for (i = 1; i + 1 < n; i++) begin
			span = nf / factorial(i);
			delta = nf / factorial(i + 1);
			rem = 64'(r) % (span + span);
			right = (rem >= span);
			rem2 = right ? rem - span : rem;
			if (right) res.direction_bits[n-1-i] = 1'b1;
			if (rem2 < span - delta) res.active_bits[n-1-i] = 1'b1;
		end
		return res;
	endfunction

	task automatic check_field(string name, logic [PERM_W-1:0] want, logic [PERM_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Predict on every input beat and check every output beat against the oldest prediction.
	always @(posedge clk) begin
		unrank_result_t want_res;
		if (!arst_n) begin
			size_seen = SIZE_RESET;
		end else begin
			if (in_valid && in_ready) begin
				pending_perms.push_back(predict_unrank(rank, size_seen));
			end
			if (cfg_we) begin
				size_seen = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (pending_perms.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none, actual %h",
						 $time, permutation);
					error_count++;
				end else begin
					want_res = pending_perms.pop_front();
					check_field("permutation", want_res.permutation, permutation);
					check_field("positions", want_res.positions, positions);
					check_field("direction_bits", 64'(want_res.direction_bits),
						    64'(direction_bits));
					check_field("active_bits", 64'(want_res.active_bits), 64'(active_bits));
					check_field("rank_error", 64'(want_res.rank_error), 64'(rank_error));
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_left > 0) begin
				out_ready = 1'b0;
				holdoff_left--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one rank, with random idle cycles first, and wait until it is accepted.
	task automatic send_rank(logic [RANK_W-1:0] r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		rank = r;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_perms.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_size(logic [SIZE_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [RANK_W-1:0] random_rank(int n);
		longint unsigned nf, raw;
		int              pick;
		nf = factorial(n);
		raw = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 70) begin
			return RANK_W'(raw % nf);
		end else if (pick < 80) begin
			case ($urandom_range(3))
				0: return '0;
				1: return RANK_W'(1);
				2: return RANK_W'(nf - 1);
				default: return RANK_W'(nf - 2);
			endcase
		end else if (pick < 90) begin
			return RANK_W'(nf + raw % 64'd1000);
		end
		return raw[RANK_W-1:0];
	endfunction

	// Sixteen elements straight out of reset: identity, edges of the range, bad ranks.
	task automatic test_reset_size;
		longint unsigned nf;
		nf = factorial(16);
		send_rank('0);
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(2));
		send_rank(RANK_W'(nf - 1));
		send_rank(RANK_W'(nf));
		send_rank('1);
		send_rank(45'h0AAA_AAAA_AAAA);
		send_rank(45'h1555_5555_5555);
	endtask

	// Smallest sizes, a zero size, and sizes above the maximum.
	task automatic test_size_extremes;
		set_size(5'd0);
		send_rank('0);
		send_rank(RANK_W'(1));
		set_size(5'd1);
		send_rank('0);
		send_rank(RANK_W'(1));
		set_size(5'd2);
		send_rank('0);
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(2));
		set_size(5'd3);
		send_rank(RANK_W'(1));
		send_rank(RANK_W'(5));
		send_rank(RANK_W'(6));
		set_size(5'd31);
		send_rank(RANK_W'(factorial(16) - 1));
		send_rank(RANK_W'(factorial(16)));
		set_size(5'd17);
		send_rank(RANK_W'(12345));
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_output_holdoff;
		set_size(5'd4);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_left = HOLDOFF_CYCLES;
		repeat (10) send_rank(random_rank(4));
	endtask

	// Random ranks over many sizes, in each idling pattern.
	task automatic test_random_phases;
		int sizes[20] = '{16, 1, 5, 0, 31, 8, 2, 12, 17, 3, 16, 6, 13, 4, 9, 16, 7, 10, 14, 11};
		int send_pct[4] = '{0, 86, 0, 19};
		int recv_pct[4] = '{0, 0, 86, 19};
		for (int phase = 0; phase < 4; phase++) begin
			for (int chunk = 0; chunk < 5; chunk++) begin
				set_size(SIZE_W'(sizes[phase*5 + chunk]));
				send_idle_pct = send_pct[phase];
				recv_stall_pct = recv_pct[phase];
				repeat (25) send_rank(random_rank(elem_count(SIZE_W'(sizes[phase*5 + chunk]))));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		rank = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_reset_size();
		test_size_extremes();
		test_output_holdoff();
		test_random_phases();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_perms.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

/* sim.f */
design/sjt_pkg.sv
design/sjt_control.sv
design/sjt_datapath.sv
design/sjt_permutation_unrank.sv
tb/tb_top.sv
